// ===== src/kvep_pkg.sv =====
// Shared types, codes and character constants for the key/value entry parser.
`default_nettype none
package kvep_pkg;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    // Subtract from an upper-case hex letter to get its nibble value.
    localparam logic [7:0] HEX_ALPHA_OFFSET = 8'h41 - 8'd10;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAIR = 2'd1,
        KIND_OK   = 2'd2,
        KIND_BAD  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       in_value;
    } result_t;

    // Results caused by one input item, in delivery order.
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } group_t;

    function automatic result_t mk_res(kind_t kind, logic [7:0] data, logic in_value);
        result_t r;
        r.kind     = kind;
        r.data     = data;
        r.in_value = in_value;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/kvep_decode.sv =====
// Per-byte parser state and the decode of one byte into its result group.
`default_nettype none
module kvep_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      in_byte,
    input  wire logic            is_last,
    input  wire logic            consume,
    output kvep_pkg::group_t     group
);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_HEX1  = 3'd1,
        PH_HEX2  = 3'd2,
        PH_DROP  = 3'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       fiv_reg, fiv_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       esc_val_reg, esc_val_next;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic       reserved;
    logic       err;
    logic [1:0] n;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte inside {[8'h30:8'h39]})
        begin
            hex_val = in_byte[3:0];
        end
        else if (in_byte inside {[8'h41:8'h46]})
        begin
            hex_val = 4'(in_byte - kvep_pkg::HEX_ALPHA_OFFSET);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // space ! * ' ( ) ; : @ & = + $ , / ? % # [ ] LF CR TAB and the zero byte
    assign reserved = in_byte inside {8'h20, 8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h3B,
                                      8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C,
                                      8'h2F, 8'h3F, 8'h25, 8'h23, 8'h5B, 8'h5D, 8'h0A,
                                      8'h0D, 8'h09, 8'h00};

    always_comb
    begin
        phase_next       = phase_reg;
        fiv_next         = fiv_reg;
        high_nibble_next = high_nibble_reg;
        esc_val_next     = esc_val_reg;
        err              = 1'b0;
        n                = 2'd0;
        group            = '0;

        if (phase_reg == PH_DROP)
        begin
            if (is_last)
            begin
                phase_next       = PH_PLAIN;
                fiv_next         = 1'b0;
                high_nibble_next = 4'd0;
                esc_val_next     = 1'b0;
            end
        end
        else
        begin
            if (in_byte == kvep_pkg::CHAR_COLON)
            begin
                if (phase_reg != PH_PLAIN || !fiv_reg)
                begin
                    err = 1'b1;
                end
                else
                begin
                    group.res[n] = kvep_pkg::mk_res(kvep_pkg::KIND_PAIR, 8'd0, 1'b0);
                    n = n + 2'd1;
                    phase_next       = PH_PLAIN;
                    fiv_next         = 1'b0;
                    high_nibble_next = 4'd0;
                    esc_val_next     = 1'b0;
                end
            end
            else if (phase_reg == PH_HEX1)
            begin
                if (!hex_ok)
                begin
                    err = 1'b1;
                end
                else
                begin
                    high_nibble_next = hex_val;
                    phase_next       = PH_HEX2;
                end
            end
            else if (phase_reg == PH_HEX2)
            begin
                if (!hex_ok)
                begin
                    err = 1'b1;
                end
                else
                begin
                    group.res[n] = kvep_pkg::mk_res(kvep_pkg::KIND_DATA,
                                                    {high_nibble_reg, hex_val}, esc_val_reg);
                    n = n + 2'd1;
                    high_nibble_next = 4'd0;
                    phase_next       = PH_PLAIN;
                end
            end
            else if (in_byte == kvep_pkg::CHAR_PERCENT)
            begin
                esc_val_next = fiv_reg;
                phase_next   = PH_HEX1;
            end
            else if (in_byte == kvep_pkg::CHAR_EQUALS && !fiv_reg)
            begin
                fiv_next = 1'b1;
            end
            else if (reserved)
            begin
                err = 1'b1;
            end
            else
            begin
                group.res[n] = kvep_pkg::mk_res(kvep_pkg::KIND_DATA, in_byte, fiv_reg);
                n = n + 2'd1;
            end

            if (!err && is_last)
            begin
                if (phase_next != PH_PLAIN || !fiv_next)
                begin
                    err = 1'b1;
                end
                else
                begin
                    group.res[n] = kvep_pkg::mk_res(kvep_pkg::KIND_PAIR, 8'd0, 1'b0);
                    n = n + 2'd1;
                    group.res[n] = kvep_pkg::mk_res(kvep_pkg::KIND_OK, 8'd0, 1'b0);
                    n = n + 2'd1;
                    phase_next       = PH_PLAIN;
                    fiv_next         = 1'b0;
                    high_nibble_next = 4'd0;
                    esc_val_next     = 1'b0;
                end
            end

            if (err)
            begin
                group.res[n] = kvep_pkg::mk_res(kvep_pkg::KIND_BAD, 8'd0, 1'b0);
                n = n + 2'd1;
                phase_next       = is_last ? PH_PLAIN : PH_DROP;
                fiv_next         = 1'b0;
                high_nibble_next = 4'd0;
                esc_val_next     = 1'b0;
            end
        end

        group.count = n;
    end

    // Advance the parser state only when the held byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PLAIN;
            fiv_reg         <= 1'b0;
            high_nibble_reg <= 4'd0;
            esc_val_reg     <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg       <= phase_next;
            fiv_reg         <= fiv_next;
            high_nibble_reg <= high_nibble_next;
            esc_val_reg     <= esc_val_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/kvep_out.sv =====
// Result register: holds one result group and delivers it one result per transfer.
`default_nettype none
module kvep_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire kvep_pkg::group_t  group,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             kind,
    output logic [7:0]             data_byte,
    output logic                   in_value,
    output logic                   run_last
);

    kvep_pkg::group_t group_reg;
    logic             valid_reg;
    logic [1:0]       idx_reg;
    logic             xfer;
    logic             at_end;
    kvep_pkg::result_t cur;

    assign cur       = group_reg.res[idx_reg];
    assign at_end    = (idx_reg == group_reg.count - 2'd1);
    assign xfer      = valid_reg && !out_stall;
    assign free      = !valid_reg || (xfer && at_end);

    assign out_valid = valid_reg;
    assign kind      = cur.kind;
    assign data_byte = cur.data;
    assign in_value  = cur.in_value;
    assign run_last  = at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (xfer)
        begin
            if (at_end)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= group;
        end
    end

endmodule
`default_nettype wire

// ===== src/key_value_entry_parser.sv =====
// Top level of the key/value entry parser: input register, decode and result register.
//
// Usage: raw entry text enters one byte per transfer on the input channel
// (in_valid, in_stall, in_byte, is_last), is_last set on the final byte.
// Results leave one per transfer on the output channel (out_valid,
// out_stall, kind, data_byte, in_value, run_last); run_last marks the final
// result caused by one input byte. An input byte causes zero to three results.
// A byte taken is held in the input register and decoded there; its result group
// is then loaded into the result register, which shows the first result.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver does not stall; a byte with several results holds back the next byte
// until the single result register, draining one result per cycle unless stalled,
// has sent them. Bytes with no result pass regardless of the output side: an
// opening percent sign, the first hex digit, a first equals sign, dropped bytes.
// Reset: the parser returns to the start of a key, both registers empty.
// Stall: when the receiver stalls, the result register holds its result, the
// input register fills and then in_stall rises until room returns.
`default_nettype none
module key_value_entry_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      data_byte,
    output logic            in_value,
    output logic            run_last
);

    // Input register: hold one byte until the decode stage consumes it.
    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    kvep_pkg::group_t group;
    logic             out_free;
    logic             consume;
    logic             accept;

    // Consume a byte with no results at once; otherwise only once the
    // result register has room for its group.
    assign consume  = in_valid_reg && (group.count == 2'd0 || out_free);
    assign in_stall = in_valid_reg && !consume;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            last_reg <= is_last;
        end
    end

    kvep_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (byte_reg),
        .is_last (last_reg),
        .consume (consume),
        .group   (group)
    );

    kvep_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && group.count != 2'd0),
        .group     (group),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .in_value  (in_value),
        .run_last  (run_last)
    );

endmodule
`default_nettype wire

// ===== sim/key_value_entry_parser_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the key/value entry parser: directed and random entries.
module key_value_entry_parser_tb;

    // Scanner position within the current pair, mirrored from the block's behaviour
    typedef enum logic [2:0] {
        SCAN_PLAIN    = 3'd0,
        SCAN_HEX_HIGH = 3'd1,
        SCAN_HEX_LOW  = 3'd2,
        SCAN_SKIP     = 3'd3
    } scan_phase_t;

    // One result as seen on the output channel
    typedef struct packed {
        kvep_pkg::kind_t kind;
        logic [7:0]      data;
        logic            in_value;
        logic            run_last;
    } parse_result_t;

    typedef logic [7:0] text_t[$];

    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam int         RANDOM_CHARS = 80;
    localparam int         LONG_HOLD    = 64;
    localparam int         DRAIN_LIMIT  = 20000;
    localparam int         PRINT_LIMIT  = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       is_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       in_value;
    logic       run_last;

    // Predictor state: a private copy of the parser's registers
    scan_phase_t scan_phase = SCAN_PLAIN;
    logic        seen_equals = 1'b0;
    logic [3:0]  upper_nibble = 4'h0;
    logic        escape_in_value = 1'b0;

    parse_result_t pending_results[$];
    parse_result_t due_result;
    text_t         entry_text;

    // Idling controls shared between the test tasks, the sender task and the receiver process
    bit sender_gaps_off = 1'b0;
    bit sink_gaps_off = 1'b0;
    int hold_off_cycles = 0;

    int mismatch_count = 0;
    int chars_parsed = 0;
    int results_checked = 0;
    int entries_ok = 0;
    int entries_bad = 0;
    int input_stall_cycles = 0;

    key_value_entry_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .in_value  (in_value),
        .run_last  (run_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop, well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------

    // Reserved outside an escape: space ! * ' ( ) ; : @ & = + $ , / ? % # [ ]
    // LF CR TAB, plus the zero byte. Bytes from 0x80 upwards are ordinary.
    function automatic bit is_reserved_char(input logic [7:0] ch);
        case (ch)
            8'h00, 8'h09, 8'h0A, 8'h0D, 8'h20, 8'h21, 8'h23, 8'h24,
            8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
            8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Nibble of an upper-case hex digit; 16 flags anything else
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= DIGIT_ZERO && ch <= DIGIT_ZERO + 8'd9)
            return 5'(ch - DIGIT_ZERO);
        if (ch >= "A" && ch <= "F")
            return 5'(ch - kvep_pkg::HEX_ALPHA_OFFSET);
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? DIGIT_ZERO + 8'(nib) : kvep_pkg::HEX_ALPHA_OFFSET + 8'(nib);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (is_reserved_char(ch));
        return ch;
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic restart_entry();
        scan_phase = SCAN_PLAIN;
        seen_equals = 1'b0;
        upper_nibble = 4'h0;
        escape_in_value = 1'b0;
    endtask

    // Work out the results caused by one accepted character and queue them
    task automatic parse_char(input logic [7:0] ch, input logic last);
        parse_result_t burst[$];
        logic          failed;
        logic [4:0]    nib;
        failed = 1'b0;

        // After an error, swallow everything; the last byte re-arms
        if (scan_phase == SCAN_SKIP)
        begin
            if (last)
                restart_entry();
            return;
        end
        chars_parsed++;

        if (ch == kvep_pkg::CHAR_COLON)
        begin
            // A colon closes the pair only outside an escape and after an equals sign
            if (scan_phase != SCAN_PLAIN || !seen_equals)
                failed = 1'b1;
            else
            begin
                burst.push_back('{kvep_pkg::KIND_PAIR, 8'h00, 1'b0, 1'b0});
                restart_entry();
            end
        end
        else if (scan_phase == SCAN_HEX_HIGH)
        begin
            nib = hex_nibble(ch);
            if (nib[4])
                failed = 1'b1;
            else
            begin
                upper_nibble = nib[3:0];
                scan_phase = SCAN_HEX_LOW;
            end
        end
        else if (scan_phase == SCAN_HEX_LOW)
        begin
            nib = hex_nibble(ch);
            if (nib[4])
                failed = 1'b1;
            else
            begin
                burst.push_back('{kvep_pkg::KIND_DATA, {upper_nibble, nib[3:0]},
                                  escape_in_value, 1'b0});
                upper_nibble = 4'h0;
                scan_phase = SCAN_PLAIN;
            end
        end
        else if (ch == kvep_pkg::CHAR_PERCENT)
        begin
            escape_in_value = seen_equals;
            scan_phase = SCAN_HEX_HIGH;
        end
        else if (ch == kvep_pkg::CHAR_EQUALS && !seen_equals)
            seen_equals = 1'b1;
        else if (is_reserved_char(ch))
            failed = 1'b1;
        else
            burst.push_back('{kvep_pkg::KIND_DATA, ch, seen_equals, 1'b0});

        // The last byte closes the final pair and the entry
        if (!failed && last)
        begin
            if (scan_phase != SCAN_PLAIN || !seen_equals)
                failed = 1'b1;
            else
            begin
                burst.push_back('{kvep_pkg::KIND_PAIR, 8'h00, 1'b0, 1'b0});
                burst.push_back('{kvep_pkg::KIND_OK, 8'h00, 1'b0, 1'b0});
                entries_ok++;
                restart_entry();
            end
        end

        if (failed)
        begin
            burst.push_back('{kvep_pkg::KIND_BAD, 8'h00, 1'b0, 1'b0});
            entries_bad++;
            restart_entry();
            if (!last)
                scan_phase = SCAN_SKIP;
        end

        if (burst.size() > 0)
            burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i])
            pending_results.push_back(burst[i]);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one character after a random gap and hold it until the transfer
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = sender_gaps_off ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= ch;
        is_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        parse_char(ch, last);
    endtask

    // Send the assembled entry, flagging its final character
    task automatic send_entry();
        foreach (entry_text[i])
            send_char(entry_text[i], i == entry_text.size() - 1);
    endtask

    // Plain character or a well-formed escape
    task automatic add_token();
        if ($urandom_range(0, 3) == 0)
        begin
            entry_text.push_back(kvep_pkg::CHAR_PERCENT);
            entry_text.push_back(hex_digit(4'($urandom_range(0, 15))));
            entry_text.push_back(hex_digit(4'($urandom_range(0, 15))));
        end
        else
            entry_text.push_back(plain_char());
    endtask

    // key=value pairs joined by colons, keys and values possibly empty
    task automatic build_well_formed();
        int pairs;
        int len;
        entry_text = {};
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++)
        begin
            if (p > 0)
                entry_text.push_back(kvep_pkg::CHAR_COLON);
            len = $urandom_range(0, 3);
            repeat (len) add_token();
            entry_text.push_back(kvep_pkg::CHAR_EQUALS);
            len = $urandom_range(0, 3);
            repeat (len) add_token();
        end
    endtask

    // Spoil one position of the entry with a troublesome character, or cut it short
    task automatic break_entry();
        int pos;
        pos = $urandom_range(0, entry_text.size() - 1);
        case ($urandom_range(0, 5))
            0: entry_text[pos] = 8'($urandom_range(0, 255));
            1: entry_text[pos] = kvep_pkg::CHAR_COLON;
            2: entry_text[pos] = kvep_pkg::CHAR_EQUALS;
            3: entry_text[pos] = kvep_pkg::CHAR_PERCENT;
            4: entry_text[pos] = LOWER_A + 8'($urandom_range(0, 5));
            default:
            begin
                // Truncate inside a fresh escape
                while (entry_text.size() > pos + 1)
                    void'(entry_text.pop_back());
                entry_text.push_back(kvep_pkg::CHAR_PERCENT);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: draw a pause per result; a requested hold-off overrides the draw
    initial
    begin : result_sink
        int pause;
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                pause = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                pause = sink_gaps_off ? 0 : $urandom_range(0, 4);
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // Compare every transferred result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_LIMIT)
                    $display("%0t: unexpected result: expected none, got kind %0d data %h",
                             $time, kind, data_byte);
            end
            else
            begin
                due_result = pending_results.pop_front();
                if (due_result.kind !== kind || due_result.data !== data_byte ||
                    due_result.in_value !== in_value || due_result.run_last !== run_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT)
                        $display({"%0t: result mismatch: expected kind %0d data %h value %b ",
                                  "last %b, got kind %0d data %h value %b last %b"},
                                 $time, due_result.kind, due_result.data,
                                 due_result.in_value, due_result.run_last,
                                 kind, data_byte, in_value, run_last);
                end
            end
        end
        if (rst_n && in_valid && in_stall)
            input_stall_cycles++;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Escapes with digits and letters, zero and top-bit bytes, two pairs
    task automatic test_well_formed_entry();
        entry_text = '{kvep_pkg::CHAR_PERCENT, "0", "0", kvep_pkg::CHAR_EQUALS,
                       kvep_pkg::CHAR_PERCENT, "F", "F", kvep_pkg::CHAR_COLON,
                       8'h80, kvep_pkg::CHAR_EQUALS, "~"};
        send_entry();
    endtask

    // Each way an entry can go wrong, including the drop of trailing bytes
    task automatic test_malformed_entries();
        // second equals sign in one pair
        entry_text = '{kvep_pkg::CHAR_EQUALS, kvep_pkg::CHAR_EQUALS, "x", "y"};
        send_entry();
        // colon as the last byte: empty final pair
        entry_text = '{"q", kvep_pkg::CHAR_EQUALS, kvep_pkg::CHAR_COLON};
        send_entry();
        // lower-case hex digit
        entry_text = '{kvep_pkg::CHAR_PERCENT, "a", "z"};
        send_entry();
        // escape still open at the last byte
        entry_text = '{"x", kvep_pkg::CHAR_EQUALS, kvep_pkg::CHAR_PERCENT, "4"};
        send_entry();
        // pair without an equals sign, found at its colon
        entry_text = '{"k", kvep_pkg::CHAR_COLON, "m"};
        send_entry();
        // colon cutting an escape short; tab and zero are swallowed
        entry_text = '{kvep_pkg::CHAR_PERCENT, kvep_pkg::CHAR_COLON, 8'h09, 8'h00};
        send_entry();
        // zero byte on the last byte
        entry_text = '{"k", 8'h00};
        send_entry();
        // pair without an equals sign, found at the last byte
        entry_text = '{"k"};
        send_entry();
    endtask

    // Mostly well-formed entries with random content, some spoilt
    task automatic test_random_entries(input int target);
        int stop_at;
        stop_at = chars_parsed + target;
        while (chars_parsed < stop_at)
        begin
            build_well_formed();
            if ($urandom_range(0, 9) < 3)
                break_entry();
            send_entry();
        end
    endtask

    // No idling on either side
    task automatic test_full_rate_stream();
        sender_gaps_off = 1'b1;
        sink_gaps_off = 1'b1;
        test_random_entries(25);
        sender_gaps_off = 1'b0;
        sink_gaps_off = 1'b0;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_back_pressure();
        sender_gaps_off = 1'b1;
        hold_off_cycles = LONG_HOLD;
        test_random_entries(40);
        sender_gaps_off = 1'b0;
    endtask

    // Arbitrary bytes with random last flags; close with a last byte
    task automatic test_byte_noise(input int target);
        int stop_at;
        stop_at = chars_parsed + target;
        while (chars_parsed < stop_at)
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        int waited;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed_entry();
        test_malformed_entries();
        test_random_entries(RANDOM_CHARS / 2);
        test_full_rate_stream();
        test_back_pressure();
        test_byte_noise(30);
        test_random_entries(RANDOM_CHARS / 4);

        in_valid <= 1'b0;

        // Drain: wait for every predicted result, then keep watching for strays
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d results still awaited at the end",
                     $time, pending_results.size());
        end

        $display("Parsed %0d characters: %0d entries ok, %0d malformed, %0d results checked.",
                 chars_parsed, entries_ok, entries_bad, results_checked);
        $display("Input held off by the parser for %0d cycles under receiver back-pressure.",
                 input_stall_cycles);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
src/kvep_pkg.sv
src/kvep_decode.sv
src/kvep_out.sv
src/key_value_entry_parser.sv
sim/key_value_entry_parser_tb.sv
